@@ sv/l3s_pkg.sv @@
// ----------------------------------------------------------------------------
// l3s_pkg
// Shared types and codes for the three-axis line step sequencer.
// ----------------------------------------------------------------------------
package l3s_pkg;

    typedef enum logic [0:0] {
        KIND_MOVE = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SQ,
        ST_SQRT,
        ST_SQRT_RND,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

@@ sv/l3s_divider.sv @@
// ----------------------------------------------------------------------------
// l3s_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module l3s_divider #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quo
);
    import l3s_pkg::*;

    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [DEN_BITS+1:0] trial;

    // shift in one numerator bit and try a subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CW'(NUM_BITS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            trial = {rem_reg, quo_reg[NUM_BITS-1]} - {2'b00, den_reg};
            if (!trial[DEN_BITS+1])
                rem_next = trial[DEN_BITS:0];
            else
                rem_next = {rem_reg[DEN_BITS-1:0], quo_reg[NUM_BITS-1]};
            quo_next = {quo_reg[NUM_BITS-2:0], ~trial[DEN_BITS+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ sv/linear_3axis_step_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// linear_3axis_step_sequencer_core
// Straight-line three-axis step sequencer with a shared sequential datapath.
// ----------------------------------------------------------------------------
// Usage: drive kind and target_* with start high while busy is low; that cycle
// transfers the item. busy stays high while the item is worked on; one result
// then appears on step_*, moving, finished and move_accepted for exactly one
// cycle with strobe high. The receiver cannot stall; results are never held.
// All multiplication and division runs on one shared multiplier and one restoring divider.
// An accepted move passes the dispatch state, squares the deltas one axis at a
// time, searches the square root one bit at a time over POS_BITS+2 bits and
// rounds it; its strobe is registered from the rounding state.
// A tick during a move passes the dispatch state, then runs three exact
// divisions of 2*POS_BITS+4 bits, one per axis, each started from the multiply
// state and captured in the divide state when the divider is done; its strobe
// is registered from the finish state. Rejected moves, ignored moves and idle
// ticks strobe from the dispatch state. busy falls in the strobe cycle, so the
// next transfer may land in that same cycle. Reset clears the position, the
// move state, the result registers and any item in flight.
// ----------------------------------------------------------------------------
module linear_3axis_step_sequencer_core #(
    parameter int POS_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic signed [15:0] target_z,
    output logic               strobe,
    output logic signed [1:0]  step_x,
    output logic signed [1:0]  step_y,
    output logic signed [1:0]  step_z,
    output logic               moving,
    output logic               finished,
    output logic               move_accepted
);
    import l3s_pkg::*;

    localparam int PB      = POS_BITS;
    localparam int MW      = PB + 2;           // sample count / index width
    localparam int XW      = MW + 1;           // shared multiplier operand width
    localparam int SW      = 2 * PB + 2;       // sum of squares width
    localparam int NW      = PB + MW + 2;      // numerator 2*a*i+m width
    localparam int DW      = MW + 1;           // denominator 2*m width
    localparam int RBW     = $clog2(MW);       // root bit index width
    localparam int POS_TOP = (1 << PB) - 1;

    state_t state_reg, state_next;

    logic [PB-1:0]        pos_reg   [3];
    logic signed [PB:0]   dlt_reg   [3];
    logic signed [PB:0]   last_reg  [3];
    logic [PB-1:0]        tgt_reg   [3];
    logic [1:0]           st_reg    [3];
    logic [MW-1:0]        tot_reg, idx_reg;
    logic                 mv_reg;            // move in progress
    kind_t                kind_reg;
    logic [SW-1:0]        sum_reg;
    logic [MW-1:0]        root_reg;
    logic [RBW-1:0]       bit_reg;
    logic [1:0]           ax_reg;

    logic                 strobe_reg, fin_reg, acc_reg, movo_reg;
    logic signed [1:0]    sx_reg, sy_reg, sz_reg;

    logic signed [15:0]   traw   [3];
    logic [PB-1:0]        tclamp [3];
    logic                 same;
    logic signed [PB:0]   dsel, lsel;
    logic [PB-1:0]        asel;
    logic [MW-1:0]        trial;
    logic [XW-1:0]        mul_a, mul_b;
    logic [2*XW-1:0]      prod;
    logic [SW+1:0]        sum_x4;
    logic                 div_start, div_done;
    logic [NW-1:0]        div_num, div_quo;
    logic [DW-1:0]        div_den;
    logic signed [PB:0]   pnew;
    logic signed [PB+1:0] sdiff;

    // clamp targets into the position range
    always_comb
    begin
        traw[0] = target_x;
        traw[1] = target_y;
        traw[2] = target_z;
        for (int k = 0; k < 3; k++)
        begin
            if (traw[k][15])
                tclamp[k] = '0;
            else if (int'(traw[k]) > POS_TOP)
                tclamp[k] = PB'(POS_TOP);
            else
                tclamp[k] = PB'(traw[k]);
        end
    end

    // current axis delta, magnitude and previous sample offset
    always_comb
    begin
        dsel = dlt_reg[ax_reg];
        lsel = last_reg[ax_reg];
        asel = dsel[PB] ? PB'(-dsel) : PB'(dsel);
        same = (tgt_reg[0] == pos_reg[0]) && (tgt_reg[1] == pos_reg[1])
               && (tgt_reg[2] == pos_reg[2]);
    end

    // shared multiplier: squares, root trials, rounding bound, a*i
    always_comb
    begin
        trial = root_reg | (MW'(1) << bit_reg);
        case (state_reg)
            ST_SQ:
            begin
                mul_a = XW'(asel);
                mul_b = XW'(asel);
            end
            ST_SQRT:
            begin
                mul_a = XW'(trial);
                mul_b = XW'(trial);
            end
            ST_SQRT_RND:
            begin
                mul_a = {root_reg, 1'b1};
                mul_b = {root_reg, 1'b1};
            end
            default:
            begin
                mul_a = XW'(asel);
                mul_b = XW'(idx_reg);
            end
        endcase
        prod    = mul_a * mul_b;
        sum_x4  = {sum_reg, 2'b00};
        div_num = NW'({prod, 1'b0}) + NW'(tot_reg);
        div_den = {tot_reg, 1'b0};
        pnew    = dsel[PB] ? -$signed((PB+1)'(div_quo)) : $signed((PB+1)'(div_quo));
        sdiff   = (PB+2)'(pnew) - (PB+2)'(lsel);
    end

    l3s_divider #(.NUM_BITS(NW), .DEN_BITS(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
                if (kind_reg == KIND_TICK)
                    state_next = mv_reg ? ST_MUL : ST_IDLE;
                else
                    state_next = (mv_reg || same) ? ST_IDLE : ST_SQ;
            ST_SQ:
                if (ax_reg == 2'd2)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (bit_reg == '0)
                    state_next = ST_SQRT_RND;
            ST_SQRT_RND:
                state_next = ST_IDLE;
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = (ax_reg == 2'd2) ? ST_FIN : ST_MUL;
            ST_FIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        div_start = (state_reg == ST_MUL);
        busy      = (state_reg != ST_IDLE);
    end

    // move state, position and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k]  <= '0;
                dlt_reg[k]  <= '0;
                last_reg[k] <= '0;
            end
            tot_reg    <= '0;
            idx_reg    <= '0;
            mv_reg     <= 1'b0;
            ax_reg     <= '0;
            strobe_reg <= 1'b0;
            fin_reg    <= 1'b0;
            acc_reg    <= 1'b0;
            movo_reg   <= 1'b0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sz_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_DISPATCH:
                begin
                    if (kind_reg == KIND_MOVE)
                    begin
                        if (mv_reg)
                        begin
                            // reject: keep the running move
                            {sx_reg, sy_reg, sz_reg} <= '0;
                            {fin_reg, acc_reg, movo_reg} <= 3'b001;
                            strobe_reg <= 1'b1;
                        end
                        else if (same)
                        begin
                            // already there: drop the move
                            {sx_reg, sy_reg, sz_reg} <= '0;
                            {fin_reg, acc_reg, movo_reg} <= 3'b000;
                            strobe_reg <= 1'b1;
                        end
                        else
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                dlt_reg[k]  <= $signed({1'b0, tgt_reg[k]})
                                             - $signed({1'b0, pos_reg[k]});
                                last_reg[k] <= '0;
                            end
                            ax_reg <= '0;
                        end
                    end
                    else if (mv_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        ax_reg  <= '0;
                    end
                    else
                    begin
                        // idle tick: all fields zero
                        {sx_reg, sy_reg, sz_reg} <= '0;
                        {fin_reg, acc_reg, movo_reg} <= 3'b000;
                        strobe_reg <= 1'b1;
                    end
                end
                ST_SQ:
                begin
                    if (ax_reg != 2'd2)
                        ax_reg <= ax_reg + 1'b1;
                end
                ST_SQRT_RND:
                begin
                    // round the root half up and start the move
                    tot_reg <= ((2*XW)'(sum_x4) >= prod) ? root_reg + 1'b1 : root_reg;
                    idx_reg <= '0;
                    mv_reg  <= 1'b1;
                    {sx_reg, sy_reg, sz_reg} <= '0;
                    {fin_reg, acc_reg, movo_reg} <= 3'b011;
                    strobe_reg <= 1'b1;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        last_reg[ax_reg] <= pnew;
                        if (ax_reg != 2'd2)
                            ax_reg <= ax_reg + 1'b1;
                    end
                end
                ST_FIN:
                begin
                    sx_reg  <= st_reg[0];
                    sy_reg  <= st_reg[1];
                    sz_reg  <= st_reg[2];
                    acc_reg <= 1'b0;
                    if (idx_reg >= tot_reg)
                    begin
                        for (int k = 0; k < 3; k++)
                            pos_reg[k] <= pos_reg[k] + PB'(dlt_reg[k]);
                        mv_reg   <= 1'b0;
                        fin_reg  <= 1'b1;
                        movo_reg <= 1'b0;
                    end
                    else
                    begin
                        fin_reg  <= 1'b0;
                        movo_reg <= 1'b1;
                    end
                    strobe_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers: captured item, square sum, root search, steps
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_reg <= kind_t'(kind);
                    for (int k = 0; k < 3; k++)
                        tgt_reg[k] <= tclamp[k];
                end
            end
            ST_DISPATCH:
                sum_reg <= '0;
            ST_SQ:
            begin
                sum_reg <= sum_reg + SW'(prod);
                if (ax_reg == 2'd2)
                begin
                    root_reg <= '0;
                    bit_reg  <= RBW'(MW - 1);
                end
            end
            ST_SQRT:
            begin
                if (prod <= (2*XW)'(sum_reg))
                    root_reg <= trial;
                bit_reg <= bit_reg - 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                    st_reg[ax_reg] <= sdiff[1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign strobe        = strobe_reg;
    assign step_x        = sx_reg;
    assign step_y        = sy_reg;
    assign step_z        = sz_reg;
    assign moving        = movo_reg;
    assign finished      = fin_reg;
    assign move_accepted = acc_reg;

endmodule

@@ bench/linear_3axis_step_sequencer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_3axis_step_sequencer_core_tb
// Self-checking bench for the line step sequencer: moves and ticks are
// queued and driven through the start/busy transfer, every result is checked
// field by field against a line-sampling predictor kept in the bench.
// ----------------------------------------------------------------------------
module linear_3axis_step_sequencer_core_tb;
    import l3s_pkg::*;

    localparam int POS_BITS  = 15;
    localparam int POS_TOP   = (1 << POS_BITS) - 1;
    localparam int CYCLE_CAP = 2000000;

    typedef struct {
        kind_t              kind;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] tz;
        bit                 drain;   // hold off until nothing is expected
    } cmd_t;

    typedef struct {
        logic signed [1:0] sx;
        logic signed [1:0] sy;
        logic signed [1:0] sz;
        logic              moving;
        logic              finished;
        logic              accepted;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic kind = 1'b0;
    logic signed [15:0] target_x = '0, target_y = '0, target_z = '0;
    logic busy, strobe, moving, finished, move_accepted;
    logic signed [1:0] step_x, step_y, step_z;

    linear_3axis_step_sequencer_core #(.POS_BITS(POS_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .strobe(strobe), .step_x(step_x), .step_y(step_y), .step_z(step_z),
        .moving(moving), .finished(finished), .move_accepted(move_accepted)
    );

    always #5 clk = ~clk;

    cmd_t  cmd_q[$];
    step_t step_q[$];
    int    errors = 0;
    bit    feed_done = 0;

    // predictor state
    longint pos[3] = '{0, 0, 0};
    longint dvec[3] = '{0, 0, 0};
    longint prev_off[3] = '{0, 0, 0};
    longint n_samples = 0, n_index = 0;
    bit     in_motion = 0;

    function automatic longint isqrt_round(longint s);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'h8000_0000;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >>> 1;
            if (mid * mid <= s) lo = mid;
            else hi = mid - 1;
        end
        if (4 * s >= (2 * lo + 1) * (2 * lo + 1)) lo++;
        return lo;
    endfunction

    function automatic longint line_offset(longint d, longint i, longint m);
        longint a, q;
        a = (d < 0) ? -d : d;
        q = (2 * a * i + m) / (2 * m);
        return (d < 0) ? -q : q;
    endfunction

    function automatic step_t predict_step(cmd_t c);
        step_t  r;
        longint t[3];
        longint sq, off;
        bit     same;
        r = '{default: '0};
        if (c.kind == KIND_MOVE)
        begin
            if (in_motion) r.moving = 1'b1;
            else
            begin
                t[0] = c.tx; t[1] = c.ty; t[2] = c.tz;
                same = 1;
                for (int k = 0; k < 3; k++)
                begin
                    if (t[k] < 0) t[k] = 0;
                    if (t[k] > POS_TOP) t[k] = POS_TOP;
                    if (t[k] != pos[k]) same = 0;
                end
                if (!same)
                begin
                    sq = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        dvec[k] = t[k] - pos[k];
                        prev_off[k] = 0;
                        sq += dvec[k] * dvec[k];
                    end
                    n_samples = isqrt_round(sq);
                    n_index = 0;
                    in_motion = 1;
                    r.moving = 1'b1;
                    r.accepted = 1'b1;
                end
            end
        end
        else if (in_motion)
        begin
            n_index++;
            for (int k = 0; k < 3; k++)
            begin
                off = line_offset(dvec[k], n_index, n_samples);
                case (k)
                    0: r.sx = 2'(off - prev_off[k]);
                    1: r.sy = 2'(off - prev_off[k]);
                    default: r.sz = 2'(off - prev_off[k]);
                endcase
                prev_off[k] = off;
            end
            if (n_index >= n_samples)
            begin
                for (int k = 0; k < 3; k++) pos[k] = (pos[k] + dvec[k]) & POS_TOP;
                in_motion = 0;
                r.finished = 1'b1;
            end
            else r.moving = 1'b1;
        end
        return r;
    endfunction

    // short-range coordinates, with negatives that clamp to zero
    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'(-1 - int'($urandom_range(0, 32767)));
            1: return 16'sh8000;
            default: return 16'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic push_move(logic signed [15:0] x, y, z);
        cmd_q.push_back('{KIND_MOVE, x, y, z, 1'b0});
    endtask

    task automatic push_ticks(int n);
        for (int i = 0; i < n; i++)
            cmd_q.push_back('{KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0});
    endtask

    // build the stimulus
    initial
    begin
        int count, d;
        // directed: idle tick, ignored move, short moves, clamps, reject
        push_ticks(1);
        push_move(0, 0, 0);
        push_move(3, 1, 2);
        push_move(5, 5, 5);
        push_ticks(5);
        push_move(16'sh8000, -16'sd5, -16'sd1);
        push_ticks(4);
        push_move(1, 0, 0);
        push_ticks(1);
        // random: mostly short moves, each followed by a random run of ticks
        count = 0;
        while (count < 900)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                push_move(rand_coord(), rand_coord(), rand_coord());
                d = $urandom_range(0, 6);
            end
            else
            begin
                push_move(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                          16'($urandom_range(0, 40)));
                d = $urandom_range(10, 80);
            end
            if ($urandom_range(0, 19) == 0) cmd_q[$].drain = 1;
            push_ticks(d);
            count += d + 1;
        end
        // far targets last: a long move, then rejected moves behind it
        push_move(16'sh7fff, 0, 0);
        cmd_q[$].drain = 1;
        push_move(0, 1, 1);
        push_move(16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_move(16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_ticks(20);
        feed_done = 1;
    end

    // reset
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: bursts with random gaps, changes on the falling edge
    int burst_left = 0, gap_left = 0;
    int issued = 0, taken = 0;
    bit sent_all = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // hold the current item until it transfers
            if (!(start && taken < issued))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_q.size() == 0)
                begin
                    start <= 1'b0;
                    if (feed_done) sent_all = 1;
                end
                else if (cmd_q[0].drain && step_q.size() != 0)
                begin
                    start <= 1'b0;
                end
                else
                begin
                    kind     <= cmd_q[0].kind;
                    target_x <= cmd_q[0].tx;
                    target_y <= cmd_q[0].ty;
                    target_z <= cmd_q[0].tz;
                    start    <= 1'b1;
                    issued++;
                    void'(cmd_q.pop_front());
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end
            end
        end
    end

    // monitor: record transfers and check results on the rising edge
    always @(posedge clk)
    begin
        cmd_t  c;
        step_t e;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (step_q.size() == 0)
                begin
                    $error("result with nothing expected");
                    errors++;
                end
                else
                begin
                    e = step_q.pop_front();
                    if (step_x !== e.sx)
                    begin
                        $error("step_x exp %0d got %0d", e.sx, step_x); errors++;
                    end
                    if (step_y !== e.sy)
                    begin
                        $error("step_y exp %0d got %0d", e.sy, step_y); errors++;
                    end
                    if (step_z !== e.sz)
                    begin
                        $error("step_z exp %0d got %0d", e.sz, step_z); errors++;
                    end
                    if (moving !== e.moving)
                    begin
                        $error("moving exp %0b got %0b", e.moving, moving); errors++;
                    end
                    if (finished !== e.finished)
                    begin
                        $error("finished exp %0b got %0b", e.finished, finished); errors++;
                    end
                    if (move_accepted !== e.accepted)
                    begin
                        $error("move_accepted exp %0b got %0b", e.accepted, move_accepted);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                c.kind = kind_t'(kind);
                c.tx = target_x; c.ty = target_y; c.tz = target_z; c.drain = 0;
                step_q.push_back(predict_step(c));
                taken++;
            end
        end
    end

    // end of run and watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (!(sent_all && !start && step_q.size() == 0) && cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_CAP)
        begin
            $display("linear_3axis_step_sequencer_core verification failed");
            $finish;
        end
        else
        begin
            repeat (120) @(posedge clk);
            if (errors == 0 && step_q.size() == 0)
                $display("linear_3axis_step_sequencer_core verification clean");
            else
                $display("linear_3axis_step_sequencer_core verification failed");
            $finish;
        end
    end
endmodule

@@ filelist.f @@
sv/l3s_pkg.sv
sv/l3s_divider.sv
sv/linear_3axis_step_sequencer_core.sv
bench/linear_3axis_step_sequencer_core_tb.sv
